>>> rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the script text tokenizer
// Character codes, event, kind and warning codes, lexer modes, result
// records and the character class helpers.
// ----------------------------------------------------------------------------
package stt_pkg;

   // counter widths and the fixed widths of the result fields
   localparam int LINE_BITS         = 20;
   localparam int COLUMN_BITS       = 16;
   localparam int LINE_FIELD_BITS   = 20;
   localparam int COLUMN_FIELD_BITS = 16;

   // stream word widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 56;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - (2 + 4 + 8 + 2 + LINE_FIELD_BITS
                                                   + COLUMN_FIELD_BITS);

   // saturation limits
   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
   localparam logic [LINE_BITS-1:0]   LINE_ONE   = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COLUMN_ONE = COLUMN_BITS'(1);

   // character codes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_UNDER  = 8'h5f;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_DOT    = 8'h2e;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5a;

   // event codes
   localparam logic [1:0] EV_VALUE = 2'd0;
   localparam logic [1:0] EV_END   = 2'd1;
   localparam logic [1:0] EV_WARN  = 2'd2;

   // token kinds
   localparam logic [3:0] K_KEYWORD = 4'd0;
   localparam logic [3:0] K_INTEGER = 4'd1;
   localparam logic [3:0] K_FLOAT   = 4'd2;
   localparam logic [3:0] K_STRING  = 4'd3;
   localparam logic [3:0] K_LBRACE  = 4'd4;
   localparam logic [3:0] K_RBRACE  = 4'd5;
   localparam logic [3:0] K_COLON   = 4'd6;
   localparam logic [3:0] K_EOF     = 4'd7;
   localparam logic [3:0] K_ILLEGAL = 4'd8;

   // warning codes
   localparam logic [1:0] W_NONE    = 2'd0;
   localparam logic [1:0] W_SLASH   = 2'd1;
   localparam logic [1:0] W_UNTERM  = 2'd2;
   localparam logic [1:0] W_ILLEGAL = 2'd3;

   // lexer modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SLASH   = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_KEYWORD = 3'd3,
      MODE_STRING  = 3'd4,
      MODE_NUM_INT = 3'd5,
      MODE_NUM_FLT = 3'd6,
      MODE_NUM_DOT = 3'd7
   } mode_type;

   // one result word, without the end-of-run flag
   typedef struct packed {
      logic [1:0]                   event_res;
      logic [3:0]                   token_kind;
      logic [7:0]                   value_byte;
      logic [1:0]                   warning;
      logic [LINE_FIELD_BITS-1:0]   line_number;
      logic [COLUMN_FIELD_BITS-1:0] column_number;
   } result_type;

   // lexer inputs: current state and the byte at hand
   typedef struct packed {
      mode_type               mode;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
      logic [7:0]             text_byte;
      logic                   end_of_input;
   } lex_in_type;

   // lexer outputs: up to three results and the next state
   typedef struct packed {
      result_type [2:0]       res;
      logic [1:0]             count;
      mode_type               mode;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
   } lex_out_type;

   // character classes
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

>>> rtl/stt_lexer.sv
// ----------------------------------------------------------------------------
// stt_lexer: tokenizer step logic
// Combinational step for one byte: mode transition, line and column update
// and the list of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module stt_lexer (
   input  stt_pkg::lex_in_type  lex_i,
   output stt_pkg::lex_out_type lex_o
);

   // build one result word from the counts at that point
   function automatic stt_pkg::result_type mk(
      input logic [1:0]                      ev,
      input logic [3:0]                      kind,
      input logic [7:0]                      val,
      input logic [1:0]                      warn,
      input logic [stt_pkg::LINE_BITS-1:0]   line,
      input logic [stt_pkg::COLUMN_BITS-1:0] col
   );
      stt_pkg::result_type r;
      r.event_res     = ev;
      r.token_kind    = kind;
      r.value_byte    = val;
      r.warning       = warn;
      r.line_number   = stt_pkg::LINE_FIELD_BITS'(line);
      r.column_number = stt_pkg::COLUMN_FIELD_BITS'(col);
      return r;
   endfunction

   stt_pkg::result_type [3:0]           r;
   logic [2:0]                          n;
   stt_pkg::mode_type                   mode;
   logic [stt_pkg::LINE_BITS-1:0]       line;
   logic [stt_pkg::COLUMN_BITS-1:0]     col;
   logic [7:0]                          c;
   logic                                do_idle;
   logic [stt_pkg::LINE_BITS-1:0]       line_nl;
   logic [stt_pkg::COLUMN_BITS-1:0]     col_up;

   // saturating counter steps from the incoming state
   assign line_nl = (lex_i.line != stt_pkg::LINE_MAX) ? lex_i.line + stt_pkg::LINE_ONE
                                                      : lex_i.line;
   assign col_up  = (lex_i.col != stt_pkg::COLUMN_MAX) ? lex_i.col + stt_pkg::COLUMN_ONE
                                                       : lex_i.col;

   // mode handling, re-examination in idle, end of input
   always_comb begin
      r       = '0;
      n       = 3'd0;
      mode    = lex_i.mode;
      line    = lex_i.line;
      col     = lex_i.col;
      c       = lex_i.text_byte;
      do_idle = 1'b0;

      unique case (lex_i.mode)
         stt_pkg::MODE_IDLE: begin
            do_idle = 1'b1;
         end
         stt_pkg::MODE_SLASH: begin
            if (c != stt_pkg::CH_SLASH) begin
               r[n[1:0]] = mk(stt_pkg::EV_WARN, stt_pkg::K_KEYWORD, 8'd0, stt_pkg::W_SLASH,
                              line, col);
               n = n + 3'd1;
            end
            mode = stt_pkg::MODE_COMMENT;
         end
         stt_pkg::MODE_COMMENT: begin
            if (c == stt_pkg::CH_LF) begin
               line = line_nl;
               col  = stt_pkg::COLUMN_ONE;
               mode = stt_pkg::MODE_IDLE;
            end else begin
               col = col_up;
            end
         end
         stt_pkg::MODE_KEYWORD: begin
            if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == stt_pkg::CH_UNDER ||
                c == stt_pkg::CH_MINUS || c == stt_pkg::CH_DOT) begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end else begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_KEYWORD, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
               mode    = stt_pkg::MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         stt_pkg::MODE_STRING: begin
            if (c == stt_pkg::CH_QUOTE) begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_STRING, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
               mode = stt_pkg::MODE_IDLE;
            end else if (c == stt_pkg::CH_LF || c == stt_pkg::CH_RPAREN) begin
               // unterminated string, the closing byte is looked at again
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_STRING, 8'd0, stt_pkg::W_UNTERM,
                              line, col);
               n = n + 3'd1;
               mode    = stt_pkg::MODE_IDLE;
               do_idle = 1'b1;
            end else begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end
         end
         stt_pkg::MODE_NUM_INT, stt_pkg::MODE_NUM_FLT: begin
            if (c == stt_pkg::CH_DOT) begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
               mode = stt_pkg::MODE_NUM_DOT;
            end else if (stt_pkg::is_digit(c)) begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end else begin
               r[n[1:0]] = mk(stt_pkg::EV_END,
                              (lex_i.mode == stt_pkg::MODE_NUM_INT) ? stt_pkg::K_INTEGER
                                                                     : stt_pkg::K_FLOAT,
                              8'd0, stt_pkg::W_NONE, line, col);
               n = n + 3'd1;
               mode    = stt_pkg::MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         stt_pkg::MODE_NUM_DOT: begin
            if (stt_pkg::is_digit(c)) begin
               col = col_up;
               r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
               mode = stt_pkg::MODE_NUM_FLT;
            end else begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_FLOAT, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
               mode    = stt_pkg::MODE_IDLE;
               do_idle = 1'b1;
            end
         end
      endcase

      // byte examined in idle mode
      if (do_idle) begin
         col = col_up;
         if (stt_pkg::is_space(c) || c == stt_pkg::CH_LPAREN || c == stt_pkg::CH_RPAREN ||
             c == stt_pkg::CH_SEMI) begin
            if (c == stt_pkg::CH_LF) begin
               line = line_nl;
               col  = stt_pkg::COLUMN_ONE;
            end
         end else if (c == stt_pkg::CH_SLASH) begin
            mode = stt_pkg::MODE_SLASH;
         end else if (stt_pkg::is_alpha(c) || c == stt_pkg::CH_STAR ||
                      c == stt_pkg::CH_UNDER || c == stt_pkg::CH_DOT) begin
            r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                           line, col);
            n = n + 3'd1;
            mode = stt_pkg::MODE_KEYWORD;
         end else if (c == stt_pkg::CH_QUOTE) begin
            mode = stt_pkg::MODE_STRING;
         end else if (stt_pkg::is_digit(c) || c == stt_pkg::CH_MINUS) begin
            r[n[1:0]] = mk(stt_pkg::EV_VALUE, stt_pkg::K_KEYWORD, c, stt_pkg::W_NONE,
                           line, col);
            n = n + 3'd1;
            mode = stt_pkg::MODE_NUM_INT;
         end else if (c == stt_pkg::CH_LBRACE) begin
            r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_LBRACE, 8'd0, stt_pkg::W_NONE,
                           line, col);
            n = n + 3'd1;
         end else if (c == stt_pkg::CH_RBRACE) begin
            r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_RBRACE, 8'd0, stt_pkg::W_NONE,
                           line, col);
            n = n + 3'd1;
         end else if (c == stt_pkg::CH_COLON) begin
            r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_COLON, 8'd0, stt_pkg::W_NONE,
                           line, col);
            n = n + 3'd1;
         end else begin
            r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_ILLEGAL, 8'd0, stt_pkg::W_ILLEGAL,
                           line, col);
            n = n + 3'd1;
         end
      end

      // end of input: close what is open, then end-of-file
      if (lex_i.end_of_input) begin
         unique case (mode)
            stt_pkg::MODE_SLASH: begin
               r[n[1:0]] = mk(stt_pkg::EV_WARN, stt_pkg::K_KEYWORD, 8'd0, stt_pkg::W_SLASH,
                              line, col);
               n = n + 3'd1;
            end
            stt_pkg::MODE_KEYWORD: begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_KEYWORD, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end
            stt_pkg::MODE_STRING: begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_STRING, 8'd0, stt_pkg::W_UNTERM,
                              line, col);
               n = n + 3'd1;
            end
            stt_pkg::MODE_NUM_INT: begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_INTEGER, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end
            stt_pkg::MODE_NUM_FLT, stt_pkg::MODE_NUM_DOT: begin
               r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_FLOAT, 8'd0, stt_pkg::W_NONE,
                              line, col);
               n = n + 3'd1;
            end
            stt_pkg::MODE_IDLE, stt_pkg::MODE_COMMENT: begin
            end
         endcase
         mode = stt_pkg::MODE_IDLE;
         r[n[1:0]] = mk(stt_pkg::EV_END, stt_pkg::K_EOF, 8'd0, stt_pkg::W_NONE, line, col);
         n = n + 3'd1;
      end

      // four results: the value of the one-character token in slot one is dropped
      if (n[2]) begin
         lex_o.res   = {r[3], r[2], r[0]};
         lex_o.count = 2'd3;
      end else begin
         lex_o.res   = r[2:0];
         lex_o.count = n[1:0];
      end
      lex_o.mode = mode;
      lex_o.line = line;
      lex_o.col  = col;
   end

endmodule

>>> rtl/stt_rsp_buf.sv
// ----------------------------------------------------------------------------
// stt_rsp_buf: result word buffer
// Holds the up to three result words of one byte and hands them out one per
// cycle while rsp_ready is high, flagging the final word of the run.
// ----------------------------------------------------------------------------
module stt_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  stt_pkg::result_type [2:0] load_res,
   input  logic [1:0]               load_count,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output stt_pkg::result_type      rsp_res,
   output logic                     rsp_last
);

   logic [1:0]                num_ff;
   logic [1:0]                num_in;
   stt_pkg::result_type [2:0] res_ff;
   stt_pkg::result_type [2:0] res_in;
   logic                      pop;

   // handshake toward the result side
   assign pop       = (num_ff != 2'd0) && rsp_ready;
   assign can_load  = (num_ff == 2'd0) || ((num_ff == 2'd1) && rsp_ready);
   assign rsp_valid = (num_ff != 2'd0);
   assign rsp_res   = res_ff[0];
   assign rsp_last  = (num_ff == 2'd1);

   // next fill and contents: load a fresh run or shift one word out
   always_comb begin
      num_in = num_ff;
      res_in = res_ff;
      if (load) begin
         num_in = load_count;
         res_in = load_res;
      end else if (pop) begin
         num_in = num_ff - 2'd1;
         res_in = {res_ff[2], res_ff[2], res_ff[1]};
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= 2'd0;
      end else begin
         num_ff <= num_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

`ifndef ASSERT_OFF
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result buffer loaded while words still pending");
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |=> num_ff != 2'd0)
      else $error("result buffer empty after a load");
`endif

endmodule

>>> rtl/script_text_tokenizer_top.sv
// ----------------------------------------------------------------------------
// script_text_tokenizer_top: script text tokenizer
// One text byte per word in; value bytes, token ends and warnings out, with
// line and column positions.
//
//   channel  dir  payload                                        last
//   req      in   tdata[7:0] text_byte                           end_of_input
//   rsp      out  tdata event,kind,value,warning,line,column     last_of_run
//
// An accepted byte waits in the input register; the lexer step then updates the
// mode and counters and loads its results into the output buffer. A byte giving
// zero or one result keeps a rate of one byte per cycle while rsp_tready is high;
// more results hold the next byte until the one-word-per-cycle output buffer is
// at its last word. Reset (synchronous) sets idle mode, line 1, column 1.
// ----------------------------------------------------------------------------
module script_text_tokenizer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [stt_pkg::REQ_DATA_BITS-1:0] req_tdata,   // text_byte
   input  logic                              req_tlast,   // end_of_input
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // event_res, token_kind, value_byte, warning, line_number, column_number
   output logic [stt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast    // last_of_run
);

   logic                               in_valid_ff;
   logic                               in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic                               in_eoi_ff;
   stt_pkg::mode_type                  mode_ff;
   stt_pkg::mode_type                  mode_in;
   logic [stt_pkg::LINE_BITS-1:0]      line_ff;
   logic [stt_pkg::LINE_BITS-1:0]      line_in;
   logic [stt_pkg::COLUMN_BITS-1:0]    col_ff;
   logic [stt_pkg::COLUMN_BITS-1:0]    col_in;
   stt_pkg::lex_in_type                lex_in;
   stt_pkg::lex_out_type               lex_out;
   logic                               can_load;
   logic                               fire;
   logic                               load;
   logic                               req_accept;
   stt_pkg::result_type                head;

   // step fires when its results fit in the buffer
   assign fire       = in_valid_ff && (can_load || (lex_out.count == 2'd0));
   assign load       = fire && (lex_out.count != 2'd0);
   assign req_tready = !in_valid_ff || fire;
   assign req_accept = req_tvalid && req_tready;

   // input register
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata[7:0];
         in_eoi_ff  <= req_tlast;
      end
   end

   // lexer step
   assign lex_in.mode         = mode_ff;
   assign lex_in.line         = line_ff;
   assign lex_in.col          = col_ff;
   assign lex_in.text_byte    = in_byte_ff;
   assign lex_in.end_of_input = in_eoi_ff;

   stt_lexer u_lexer (
      .lex_i (lex_in),
      .lex_o (lex_out)
   );

   // lexer state
   assign mode_in = fire ? lex_out.mode : mode_ff;
   assign line_in = fire ? lex_out.line : line_ff;
   assign col_in  = fire ? lex_out.col  : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stt_pkg::MODE_IDLE;
         line_ff <= stt_pkg::LINE_ONE;
         col_ff  <= stt_pkg::COLUMN_ONE;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

   // result buffer
   stt_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_res   (lex_out.res),
      .load_count (lex_out.count),
      .can_load   (can_load),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_res    (head),
      .rsp_last   (rsp_tlast)
   );

   // result word packing, first field lowest
   assign rsp_tdata = {{stt_pkg::RSP_PAD_BITS{1'b0}}, head.column_number, head.line_number,
                       head.warning, head.value_byte, head.token_kind, head.event_res};

`ifndef ASSERT_OFF
   a_eoi_gives_result: assert property (@(posedge clock) disable iff (reset)
      (fire && in_eoi_ff) |-> lex_out.count != 2'd0)
      else $error("end of input produced no result");
   a_eoi_to_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && in_eoi_ff) |=> mode_ff == stt_pkg::MODE_IDLE)
      else $error("mode not idle after end of input");
   a_line_monotonic: assert property (@(posedge clock) disable iff (reset)
      fire |=> line_ff >= $past(line_ff))
      else $error("line count went backward");
   a_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      fire |=> col_ff != '0)
      else $error("column count reached zero");
`endif

endmodule
